// ===== design/rhh_pkg.sv =====
package rhh_pkg;

    // Channel and field widths
    localparam int CH_W    = 8;
    localparam int NUM_W   = 16;    // dividend width of both divider lanes
    localparam int DEN_W   = 9;     // divisor width of both divider lanes
    localparam int QUO_W   = 8;     // quotient bits, one per divider stage

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Hue arithmetic
    localparam int HUE_MUL     = 120;   // 2 * 60 degrees per sector half
    localparam int DEG_FULL    = 360;
    localparam int HUE_SCALE   = 17;    // 255/360 = 17/24, first times 17 then / 8
    localparam int SCALE_SHIFT = 3;
    localparam int RECIP_3     = 683;   // floor(x/3) = (x * 683) >> 11 for x < 1536
    localparam int RECIP_SHIFT = 11;
    localparam int SAT_FULL    = 255;
    localparam int HSL_TWICE   = 510;

    // Sector offsets: base angle minus 60 degrees
    localparam int OFF_RED   = 300;
    localparam int OFF_GREEN = 60;
    localparam int OFF_BLUE  = 180;

    typedef enum logic [0:0] {
        MODE_HSV = 1'b0,
        MODE_HSL = 1'b1
    } t_rhh_mode;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_rhh_sector;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rhh_pixel;

    typedef struct packed {
        logic [CH_W-1:0] hue;
        logic [CH_W-1:0] saturation;
        logic [CH_W-1:0] value_or_lightness;
    } t_rhh_result;

    // Fields that bypass the dividers
    typedef struct packed {
        t_rhh_sector     sector;
        logic            gray;
        logic [CH_W-1:0] vl;
    } t_rhh_side;

    // One classified pixel waiting in the queue
    typedef struct packed {
        logic [NUM_W-1:0] hue_num;
        logic [DEN_W-1:0] hue_den;
        logic [NUM_W-1:0] sat_num;
        logic [DEN_W-1:0] sat_den;
        t_rhh_side        side;
    } t_rhh_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_rhh_qstat;

endpackage

// ===== design/rhh_front.sv =====
module rhh_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_valid,
    input  rhh_pkg::t_rhh_pixel i_pixel,
    input  rhh_pkg::t_rhh_qstat i_qstat,
    output logic              o_stall,
    output logic              o_push,
    output rhh_pkg::t_rhh_job o_job
);
    import rhh_pkg::*;

    t_rhh_mode       r_mode;
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] mn;
    logic [CH_W-1:0] delta;
    logic [CH_W:0]   s2;
    logic [CH_W:0]   hsl_den;
    logic [CH_W+1:0] u_wide;
    logic [CH_W:0]   u;
    t_rhh_sector     sector;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HSV;
        end else if (i_cfg_we) begin
            r_mode <= t_rhh_mode'(i_cfg_wdata);
        end
    end

    // Accept a word whenever the queue has room
    assign o_stall = i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    // Extremes and sector; red wins ties, then green
    always_comb begin
        mx = i_pixel.red;
        mn = i_pixel.red;
        if (i_pixel.green > mx) mx = i_pixel.green;
        if (i_pixel.blue > mx)  mx = i_pixel.blue;
        if (i_pixel.green < mn) mn = i_pixel.green;
        if (i_pixel.blue < mn)  mn = i_pixel.blue;
        delta = mx - mn;
        if (i_pixel.red == mx) begin
            sector = SEC_RED;
        end else if (i_pixel.green == mx) begin
            sector = SEC_GREEN;
        end else begin
            sector = SEC_BLUE;
        end
    end

    // Offset channel difference, lies in 0 .. 2*delta
    always_comb begin
        unique case (sector)
            SEC_RED: begin
                u_wide = {2'b0, i_pixel.green} + {2'b0, delta} - {2'b0, i_pixel.blue};
            end
            SEC_GREEN: begin
                u_wide = {2'b0, i_pixel.blue} + {2'b0, delta} - {2'b0, i_pixel.red};
            end
            default: begin
                u_wide = {2'b0, i_pixel.red} + {2'b0, delta} - {2'b0, i_pixel.green};
            end
        endcase
        u = u_wide[CH_W:0];
    end

    // HSL denominator: 255 - |max + min - 255|
    always_comb begin
        s2 = {1'b0, mx} + {1'b0, mn};
        if (s2 <= (CH_W+1)'(SAT_FULL)) begin
            hsl_den = s2;
        end else begin
            hsl_den = (CH_W+1)'(HSL_TWICE) - s2;
        end
    end

    // Build the queue entry
    always_comb begin
        o_job.hue_num     = NUM_W'(u) * NUM_W'(HUE_MUL) + NUM_W'(delta);
        o_job.hue_den     = {delta, 1'b0};
        o_job.sat_num     = NUM_W'(delta) * NUM_W'(SAT_FULL);
        o_job.side.sector = sector;
        o_job.side.gray   = (delta == '0);
        if (r_mode == MODE_HSV) begin
            o_job.sat_den = {1'b0, mx};
            o_job.side.vl = mx;
        end else begin
            o_job.sat_den = hsl_den;
            o_job.side.vl = s2[CH_W:1];
        end
    end

endmodule

// ===== design/rhh_fifo.sv =====
module rhh_fifo #(
    parameter int DEPTH = rhh_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rhh_pkg::t_rhh_job   i_job,
    input  logic                i_pop,
    output rhh_pkg::t_rhh_job   o_job,
    output rhh_pkg::t_rhh_qstat o_qstat
);
    import rhh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_rhh_job         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;

    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == CNT_W'(DEPTH));
    assign o_job         = r_mem[r_rd];

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qstat.full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qstat.empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

// ===== design/rhh_div.sv =====
module rhh_div (
    input  logic                      i_clk,
    input  logic                      i_adv,
    input  logic [rhh_pkg::NUM_W-1:0] i_num,
    input  logic [rhh_pkg::DEN_W-1:0] i_den,
    output logic [rhh_pkg::QUO_W-1:0] o_quo
);
    import rhh_pkg::*;

    // One restoring step per stage; the dividend is below den * 2^QUO_W
    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_low [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [DEN_W-1:0] n_rem [QUO_W];
    logic [QUO_W-1:0] n_low [QUO_W];
    logic [QUO_W-1:0] n_quo [QUO_W];

    always_comb begin
        logic [DEN_W-1:0] src_rem;
        logic [QUO_W-1:0] src_low;
        logic [DEN_W-1:0] src_den;
        logic [QUO_W-1:0] src_quo;
        logic [DEN_W:0]   trial;
        for (int s = 0; s < QUO_W; s++) begin
            if (s == 0) begin
                src_rem = DEN_W'(i_num[NUM_W-1:QUO_W]);
                src_low = i_num[QUO_W-1:0];
                src_den = i_den;
                src_quo = '0;
            end else begin
                src_rem = r_rem[s-1];
                src_low = r_low[s-1];
                src_den = r_den[s-1];
                src_quo = r_quo[s-1];
            end
            trial    = {src_rem, src_low[QUO_W-1]};
            n_low[s] = {src_low[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, src_den}) begin
                n_rem[s] = DEN_W'(trial - {1'b0, src_den});
                n_quo[s] = {src_quo[QUO_W-2:0], 1'b1};
            end else begin
                n_rem[s] = trial[DEN_W-1:0];
                n_quo[s] = {src_quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int s = 0; s < QUO_W; s++) begin
                r_rem[s] <= n_rem[s];
                r_low[s] <= n_low[s];
                r_quo[s] <= n_quo[s];
                r_den[s] <= (s == 0) ? i_den : r_den[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

// ===== design/rhh_back.sv =====
module rhh_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rhh_pkg::t_rhh_job    i_job,
    input  rhh_pkg::t_rhh_qstat  i_qstat,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rhh_pkg::t_rhh_result o_word
);
    import rhh_pkg::*;

    localparam int DEG_W = $clog2(DEG_FULL);            // 9
    localparam int OFF_W = DEG_W + 1;                   // room for offset + quotient
    localparam int X_W   = DEG_W + 5 - SCALE_SHIFT;     // (deg*17) >> 3
    localparam int P_W   = X_W + 10;                    // x * 683

    logic             adv;
    logic [QUO_W-1:0] q_hue;
    logic [QUO_W-1:0] q_sat;

    logic             r_vld  [QUO_W];
    t_rhh_side        r_side [QUO_W];

    logic             r_a_valid;
    logic [X_W-1:0]   r_a_x;
    logic [CH_W-1:0]  r_a_sat;
    t_rhh_side        r_a_side;
    logic [X_W-1:0]   n_a_x;

    logic             r_out_valid;
    t_rhh_result      r_out;
    logic [P_W-1:0]   prod;

    // Whole pipeline moves unless the output word is held
    assign adv   = !r_out_valid || !i_stall;
    assign o_pop = adv && !i_qstat.empty;

    rhh_div u_div_hue (
        .i_clk (i_clk),
        .i_adv (adv),
        .i_num (i_job.hue_num),
        .i_den (i_job.hue_den),
        .o_quo (q_hue)
    );

    rhh_div u_div_sat (
        .i_clk (i_clk),
        .i_adv (adv),
        .i_num (i_job.sat_num),
        .i_den (i_job.sat_den),
        .o_quo (q_sat)
    );

    // Carry valid and bypass fields alongside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QUO_W; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= o_pop;
            for (int s = 1; s < QUO_W; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= i_job.side;
            for (int s = 1; s < QUO_W; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // Degrees from sector offset and rounded quotient, wrap, scale by 17/8
    always_comb begin
        logic [OFF_W-1:0]   off;
        logic [OFF_W-1:0]   deg_raw;
        logic [DEG_W-1:0]   deg;
        logic [X_W+SCALE_SHIFT-1:0] scaled;
        unique case (r_side[QUO_W-1].sector)
            SEC_RED:   off = OFF_W'(OFF_RED);
            SEC_GREEN: off = OFF_W'(OFF_GREEN);
            default:   off = OFF_W'(OFF_BLUE);
        endcase
        deg_raw = off + OFF_W'(q_hue);
        if (deg_raw >= OFF_W'(DEG_FULL)) begin
            deg = DEG_W'(deg_raw - OFF_W'(DEG_FULL));
        end else begin
            deg = deg_raw[DEG_W-1:0];
        end
        scaled = (X_W+SCALE_SHIFT)'(deg) * (X_W+SCALE_SHIFT)'(HUE_SCALE);
        n_a_x  = scaled[X_W+SCALE_SHIFT-1:SCALE_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= r_vld[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_x    <= n_a_x;
            r_a_side <= r_side[QUO_W-1];
            r_a_sat  <= r_side[QUO_W-1].gray ? '0 : q_sat;
        end
    end

    // Finish the divide by 24 with a reciprocal of three
    assign prod = P_W'(r_a_x) * P_W'(RECIP_3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.hue                <= r_a_side.gray ? '0
                                      : prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
            r_out.saturation         <= r_a_sat;
            r_out.value_or_lightness <= r_a_side.vl;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> ($stable(r_a_valid) && $stable(r_vld[QUO_W-1])))
        else $error("pipeline moved while output word was held");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.hue <= CH_W'(SAT_FULL - 1)))
        else $error("hue beyond scaled range");

    a_gray_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_side.gray) |-> (r_a_sat == '0))
        else $error("gray pixel with nonzero saturation");

endmodule

// ===== design/rgb_to_hsv_hsl.sv =====
// RGB to HSV/HSL converter for 8-bit pixels. One pixel word is taken per clock and one
// result word leaves per clock in steady flow. Each accepted word passes through the two
// eight-stage restoring dividers (one quotient bit per stage) for hue and saturation,
// then one stage for hue wrap and scale and the output register. A four-word queue sits
// between the classifying front and the divider pipeline, so input stall rises only once
// the queue has filled behind a held output. The mode bit (0 HSV, 1 HSL) is written
// through i_cfg_we/i_cfg_wdata and is sampled as each pixel enters; change it only while
// no words are in flight.
module rgb_to_hsv_hsl #(
    parameter int Q_DEPTH = rhh_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_pix_valid,
    output logic                 o_pix_stall,
    input  rhh_pkg::t_rhh_pixel  i_pixel,
    output logic                 o_hsv_valid,
    input  logic                 i_hsv_stall,
    output rhh_pkg::t_rhh_result o_hsv
);
    import rhh_pkg::*;

    t_rhh_job   push_job;
    t_rhh_job   head_job;
    t_rhh_qstat qstat;
    logic       push;
    logic       pop;

    rhh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_pix_valid),
        .i_pixel     (i_pixel),
        .i_qstat     (qstat),
        .o_stall     (o_pix_stall),
        .o_push      (push),
        .o_job       (push_job)
    );

    rhh_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    rhh_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_hsv_valid),
        .i_stall (i_hsv_stall),
        .o_word  (o_hsv)
    );

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import rhh_pkg::*;

    // One pixel on its way through the converter, with the result it must produce
    typedef struct {
        t_rhh_pixel  pixel;
        t_rhh_result result;
    } t_colour_expectation;

    class colour_scoreboard;
        t_rhh_mode           mode_copy = MODE_HSV;
        t_colour_expectation expected_colours[$];
        int unsigned         fail_count = 0;

        // Convert one pixel exactly as the block should in the current mode
        function t_rhh_result convert_pixel(t_rhh_pixel px);
            int          r, g, b, hi, lo, delta, num, deg, fold, den, sat;
            t_rhh_result res;
            r = px.red;
            g = px.green;
            b = px.blue;
            hi = r;
            lo = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            delta = hi - lo;
            res = '0;
            res.value_or_lightness = (mode_copy == MODE_HSV) ? 8'(hi) : 8'((hi + lo) / 2);
            // Gray pixels, black among them, keep hue and saturation at zero
            if (delta != 0) begin
                // Red wins ties for the maximum, then green
                if (r == hi) begin
                    num = 360 * delta + 60 * (g - b);
                end else if (g == hi) begin
                    num = 120 * delta + 60 * (b - r);
                end else begin
                    num = 240 * delta + 60 * (r - g);
                end
                // Round to whole degrees, halves up, then wrap and scale
                deg = ((2 * num + delta) / (2 * delta)) % 360;
                res.hue = 8'(deg * 255 / 360);
                if (mode_copy == MODE_HSV) begin
                    sat = 255 * delta / hi;
                end else begin
                    fold = hi + lo - 255;
                    if (fold < 0) fold = -fold;
                    den = 255 - fold;
                    sat = (den > 0) ? 255 * delta / den : 0;
                end
                if (sat > 255) sat = 255;
                res.saturation = 8'(sat);
            end
            return res;
        endfunction

        function void note_pixel(t_rhh_pixel px);
            t_colour_expectation e;
            e.pixel  = px;
            e.result = convert_pixel(px);
            expected_colours.push_back(e);
        endfunction

        function void check_result(t_rhh_result got);
            t_colour_expectation e;
            if (expected_colours.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h", $time, got);
                fail_count++;
                return;
            end
            e = expected_colours.pop_front();
            if (got.hue != e.result.hue) begin
                $display("%0t: pixel %h hue expected %0d got %0d",
                         $time, e.pixel, e.result.hue, got.hue);
                fail_count++;
            end
            if (got.saturation != e.result.saturation) begin
                $display("%0t: pixel %h saturation expected %0d got %0d",
                         $time, e.pixel, e.result.saturation, got.saturation);
                fail_count++;
            end
            if (got.value_or_lightness != e.result.value_or_lightness) begin
                $display("%0t: pixel %h value/lightness expected %0d got %0d",
                         $time, e.pixel, e.result.value_or_lightness,
                         got.value_or_lightness);
                fail_count++;
            end
        endfunction
    endclass

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 290;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_style;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_pix_valid;
    logic        o_pix_stall;
    t_rhh_pixel  i_pixel;
    logic        o_hsv_valid;
    logic        i_hsv_stall = 1'b0;
    t_rhh_result o_hsv;

    colour_scoreboard sb = new;
    int unsigned      cycle_count = 0;
    t_stall_style     stall_style = STALL_NONE;
    int unsigned      style_left = 0;

    // Extremes of every field, the three tie orders, the wrap to zero degrees,
    // rounding halves in two sectors and a near-white pixel for the HSL divisor
    t_rhh_pixel corner_pixels [13] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00,
        24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001,
        24'h080100, 24'h000801, 24'hFFFEFE
    };

    rgb_to_hsv_hsl uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix_valid (i_pix_valid),
        .o_pix_stall (o_pix_stall),
        .i_pixel     (i_pixel),
        .o_hsv_valid (o_hsv_valid),
        .i_hsv_stall (i_hsv_stall),
        .o_hsv       (o_hsv)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Record accepted pixels and check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && i_pix_valid && !o_pix_stall) sb.note_pixel(i_pixel);
        if (i_rst_n && o_hsv_valid && !i_hsv_stall) sb.check_result(o_hsv);
    end

    // Output stall: switch between free flow, light, heavy and periodic stalling
    always @(posedge i_clk) begin
        if (style_left == 0) begin
            stall_style <= t_stall_style'($urandom_range(0, 3));
            style_left  <= $urandom_range(50, 300);
        end else begin
            style_left <= style_left - 1;
        end
        case (stall_style)
            STALL_NONE: begin
                i_hsv_stall <= 1'b0;
            end
            STALL_LIGHT: begin
                i_hsv_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
                i_hsv_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_hsv_stall <= ((style_left % 24) < 12);
            end
        endcase
    end

    // Present one pixel and hold it until it is taken
    task automatic send_pixel(t_rhh_pixel px);
        i_pix_valid <= 1'b1;
        i_pixel     <= px;
        @(posedge i_clk);
        while (o_pix_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_for_results();
        i_pix_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_colours.size() != 0);
    endtask

    task automatic write_mode(t_rhh_mode m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        sb.mode_copy = m;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] extreme_channel();
        if ($urandom_range(0, 1) == 1) return 8'(255 - $urandom_range(0, 1));
        return 8'($urandom_range(0, 1));
    endfunction

    // Mostly random pixels, with gray, ties, small spreads and extremes mixed in
    function automatic t_rhh_pixel random_pixel();
        t_rhh_pixel px;
        px.red   = 8'($urandom);
        px.green = 8'($urandom);
        px.blue  = 8'($urandom);
        case ($urandom_range(0, 9))
            4: begin
                px.green = px.red;
                px.blue  = px.red;
            end
            5: begin
                case ($urandom_range(0, 2))
                    0: begin
                        px.green = px.red;
                        px.blue  = 8'($urandom_range(0, px.red));
                    end
                    1: begin
                        px.blue = px.green;
                        px.red  = 8'($urandom_range(0, px.green));
                    end
                    default: begin
                        px.blue  = px.red;
                        px.green = 8'($urandom_range(0, px.red));
                    end
                endcase
            end
            6: begin
                px.green = px.red ^ 8'($urandom_range(0, 3));
                px.blue  = px.red ^ 8'($urandom_range(0, 3));
            end
            7: begin
                px.red   = extreme_channel();
                px.green = extreme_channel();
                px.blue  = extreme_channel();
            end
            8: begin
                px.green = 8'($urandom_range(0, px.red));
                px.blue  = px.green;
            end
            9: begin
                if ($urandom_range(0, 1) == 1) begin
                    px = px | 24'hF0F0F0;
                end else begin
                    px = px & 24'h0F0F0F;
                end
            end
            default: begin
            end
        endcase
        return px;
    endfunction

    // Random pixels in bursts of random length with random gaps between them
    task automatic run_random_phase(int unsigned count, bit pause_midway);
        int unsigned burst_left;
        int unsigned gap;
        burst_left = $urandom_range(1, 40);
        for (int unsigned k = 0; k < count; k++) begin
            if (pause_midway && k == count / 2) wait_for_results();
            send_pixel(random_pixel());
            burst_left--;
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                         : $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    i_pix_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 1'b0;
        i_pix_valid <= 1'b0;
        i_pixel     <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner pixels in both modes
        write_mode(MODE_HSV);
        foreach (corner_pixels[k]) send_pixel(corner_pixels[k]);
        wait_for_results();
        write_mode(MODE_HSL);
        foreach (corner_pixels[k]) send_pixel(corner_pixels[k]);
        wait_for_results();

        // Random phases, changing mode only once the pipeline is empty
        write_mode(MODE_HSV);
        run_random_phase(PHASE_ITEMS, 1'b0);
        wait_for_results();
        write_mode(MODE_HSL);
        run_random_phase(PHASE_ITEMS, 1'b1);
        wait_for_results();
        write_mode(MODE_HSL);
        run_random_phase(PHASE_ITEMS, 1'b0);
        wait_for_results();
        write_mode(MODE_HSV);
        run_random_phase(PHASE_ITEMS, 1'b0);
        wait_for_results();
        write_mode(MODE_HSL);
        run_random_phase(PHASE_ITEMS, 1'b0);
        wait_for_results();
        write_mode(MODE_HSV);
        run_random_phase(PHASE_ITEMS, 1'b0);
        wait_for_results();

        // Let any stray word surface before judging
        repeat (20) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.expected_colours.size() == 0) begin
            $display("rgb_to_hsv_hsl test passed");
        end else begin
            $display("rgb_to_hsv_hsl test failed");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("rgb_to_hsv_hsl test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rhh_pkg.sv
design/rhh_front.sv
design/rhh_fifo.sv
design/rhh_div.sv
design/rhh_back.sv
design/rgb_to_hsv_hsl.sv
dv/testbench.sv
